FILE: hw/rtl/billboard_quad_corner_generator_unit_macros.svh
// Assertion macros shared by the billboard quad corner generator RTL.
// Each macro expands to one labeled concurrent assertion on clk and arst_n.
`ifndef BILLBOARD_QUAD_CORNER_GENERATOR_UNIT_MACROS_SVH
`define BILLBOARD_QUAD_CORNER_GENERATOR_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BQCG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BQCG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/bqcg_pkg.sv
// Package for the billboard quad corner generator: widths, constants,
// the arctangent table, the cell payload structs and the output rounding.
package bqcg_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int TAB_LEN = 24;
	localparam int VW = 28;   // vectoring x/y width
	localparam int RW = 27;   // rotation x/y width
	localparam int DW = 26;   // corner distance width
	localparam int AW = 32;   // binary angle width
	localparam logic signed [30:0] INV_GAIN = 31'sd652032874;
	localparam logic [AW-1:0] HALF_TURN = 32'h8000_0000;
	localparam logic [AW-1:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic signed [17:0] POS_MAX = 18'sd131071;
	localparam logic signed [17:0] POS_MIN = -18'sd131072;

	typedef struct packed {
		logic                 valid;
		logic                 zero;
		logic                 bottom;
		logic [15:0]          sx;
		logic [15:0]          rot;
		logic signed [VW-1:0] ax;
		logic signed [VW-1:0] ay;
		logic [AW-1:0]        az;
		logic signed [VW-1:0] bx;
		logic signed [VW-1:0] by;
	} vec_beat_t;

	typedef struct packed {
		logic                 valid;
		logic                 last;
		logic [1:0]           corner;
		logic                 flip;
		logic signed [RW-1:0] x;
		logic signed [RW-1:0] y;
		logic signed [AW-1:0] z;
	} rot_beat_t;

	function automatic logic [AW-1:0] atan_val(input int idx);
		logic [AW-1:0] r;
		unique case (idx)
			0: r = 32'd536870912;  1: r = 32'd316933405;  2: r = 32'd167458907;
			3: r = 32'd85004756;   4: r = 32'd42667331;   5: r = 32'd21354465;
			6: r = 32'd10680862;   7: r = 32'd5340245;    8: r = 32'd2670163;
			9: r = 32'd1335087;    10: r = 32'd667544;    11: r = 32'd333772;
			12: r = 32'd166886;    13: r = 32'd83443;     14: r = 32'd41722;
			15: r = 32'd20861;     16: r = 32'd10430;     17: r = 32'd5215;
			18: r = 32'd2608;      19: r = 32'd1304;      20: r = 32'd652;
			21: r = 32'd326;       22: r = 32'd163;       23: r = 32'd81;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Round a 12-fraction-bit value to Q14.4 and saturate.
	function automatic logic signed [17:0] to_q4(input logic signed [RW:0] v);
		logic signed [RW+1:0] t;
		logic signed [RW+1:0] r;
		logic signed [17:0]   o;
		t = (RW+2)'(v) + (RW+2)'(128);
		r = t >>> 8;
		if (r > (RW+2)'(POS_MAX))
			o = POS_MAX;
		else if (r < (RW+2)'(POS_MIN))
			o = POS_MIN;
		else
			o = r[17:0];
		return o;
	endfunction

endpackage

FILE: hw/rtl/bqcg_vec_cell.sv
// One vectoring CORDIC cell with two lanes: lane a gives the diagonal angle,
// lane b the magnitude. Depends on bqcg_pkg.
module bqcg_vec_cell #(
	parameter int STEP = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  bqcg_pkg::vec_beat_t  d,
	output bqcg_pkg::vec_beat_t  q
);
	import bqcg_pkg::*;

	vec_beat_t nx;

	always_comb begin
		nx = d;
		if (!d.ay[VW-1]) begin
			nx.ax = d.ax + (d.ay >>> STEP);
			nx.ay = d.ay - (d.ax >>> STEP);
			nx.az = d.az + atan_val(STEP);
		end else begin
			nx.ax = d.ax - (d.ay >>> STEP);
			nx.ay = d.ay + (d.ax >>> STEP);
			nx.az = d.az - atan_val(STEP);
		end
		if (!d.by[VW-1]) begin
			nx.bx = d.bx + (d.by >>> STEP);
			nx.by = d.by - (d.bx >>> STEP);
		end else begin
			nx.bx = d.bx - (d.by >>> STEP);
			nx.by = d.by + (d.bx >>> STEP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q <= nx;
		end
	end

endmodule

FILE: hw/rtl/bqcg_rot_cell.sv
// One rotation CORDIC cell: turns the corner vector by one table step.
// Depends on bqcg_pkg.
module bqcg_rot_cell #(
	parameter int STEP = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  bqcg_pkg::rot_beat_t  d,
	output bqcg_pkg::rot_beat_t  q
);
	import bqcg_pkg::*;

	rot_beat_t nx;

	always_comb begin
		nx = d;
		if (!d.z[AW-1]) begin
			nx.x = d.x - (d.y >>> STEP);
			nx.y = d.y + (d.x >>> STEP);
			nx.z = d.z - $signed(atan_val(STEP));
		end else begin
			nx.x = d.x + (d.y >>> STEP);
			nx.y = d.y - (d.x >>> STEP);
			nx.z = d.z + $signed(atan_val(STEP));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q <= nx;
		end
	end

endmodule

FILE: hw/rtl/billboard_quad_corner_generator_unit.sv
// Top level of the billboard quad corner generator; uses bqcg_pkg, the two
// CORDIC cell modules and the assertion macro header.
`include "billboard_quad_corner_generator_unit_macros.svh"

// Each input beat is one sprite (width, height, rotation, origin mode); the
// block returns four output beats, corners 0 to 3, with tlast on corner 3.
// A row of NS vectoring cells (CORDIC_STEPS, capped at TAB_LEN) finds the
// diagonal angle and length, a length stage applies the inverse gain with
// one multiplier, a corner sequencer issues one corner per cycle, while the
// output is not stalled, through the start vector register into a row of NS
// rotation cells, and a final register rounds and saturates to Q14.4. The
// sequencer sets the rate: it takes a new sprite only as it issues the last
// corner of the one it holds. Back pressure stalls all rotation cells at once.
module billboard_quad_corner_generator_unit #(
	parameter int CORDIC_STEPS = bqcg_pkg::CORDIC_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // size_x[15:0], size_y[31:16], rotation[47:32]
	input  logic        s_tuser,   // origin_mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // corner[1:0], pos_x[19:2], pos_y[37:20], zero pad
	output logic        m_tlast
);
	import bqcg_pkg::*;

	localparam int NS = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;

	// Flow control: the output register gates the sequencer and the rotation row.
	logic en_o;
	logic en_l;
	logic seq_free;

	// Vectoring row.
	vec_beat_t vchain [NS+1];

	always_comb begin
		vchain[0] = '0;
		vchain[0].valid = s_tvalid;
		vchain[0].bottom = s_tuser;
		vchain[0].zero = (s_tdata[15:0] == '0) && (s_tdata[31:16] == '0);
		vchain[0].sx = s_tdata[15:0];
		vchain[0].rot = s_tdata[47:32];
		vchain[0].ax = $signed(VW'({s_tdata[31:16], 8'h00}));
		vchain[0].ay = $signed(VW'({s_tdata[15:0], 8'h00}));
		vchain[0].az = '0;
		vchain[0].bx = s_tuser ? $signed(VW'({s_tdata[31:16], 9'h000}))
			: $signed(VW'({s_tdata[31:16], 8'h00}));
		vchain[0].by = $signed(VW'({s_tdata[15:0], 8'h00}));
	end

	genvar gi;
	generate
		for (gi = 0; gi < NS; gi++) begin : g_vec
			bqcg_vec_cell #(.STEP(gi)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (en_l),
				.d      (vchain[gi]),
				.q      (vchain[gi+1])
			);
		end
	endgenerate

	// Length stage: one multiply by the inverse gain, halved.
	vec_beat_t                 vend;
	logic signed [VW+30:0]     len_prod;
	logic                      len_valid_s1;
	logic                      len_bot_s1;
	logic [15:0]               len_sx_s1;
	logic [15:0]               len_rot_s1;
	logic [AW-1:0]             len_a_s1;
	logic signed [DW-1:0]      len_d_s1;

	assign vend = vchain[NS];
	assign len_prod = (vend.zero ? '0 : vend.bx) * INV_GAIN;
	assign en_l = !len_valid_s1 || seq_free;
	assign s_tready = en_l;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_valid_s1 <= 1'b0;
		end else if (en_l) begin
			len_valid_s1 <= vend.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_l) begin
			len_bot_s1 <= vend.bottom;
			len_sx_s1 <= vend.sx;
			len_rot_s1 <= vend.rot;
			len_a_s1 <= vend.zero ? '0 : vend.az;
			len_d_s1 <= len_prod[31+DW-1:31];
		end
	end

	// Corner sequencer: holds one sprite and issues its four corners.
	logic                 seq_valid_q;
	logic [1:0]           seq_cnt_q;
	logic                 seq_bot_q;
	logic [15:0]          seq_sx_q;
	logic [AW-1:0]        seq_rot_q;
	logic [AW-1:0]        seq_a_q;
	logic signed [DW-1:0] seq_len_q;
	logic                 seq_done;

	assign seq_done = seq_valid_q && en_o && (seq_cnt_q == 2'd3);
	assign seq_free = !seq_valid_q || seq_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_valid_q <= 1'b0;
			seq_cnt_q <= '0;
		end else begin
			if (seq_free) begin
				seq_valid_q <= len_valid_s1;
			end
			if (seq_valid_q && en_o) begin
				seq_cnt_q <= seq_cnt_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (seq_free && len_valid_s1) begin
			seq_bot_q <= len_bot_s1;
			seq_sx_q <= len_sx_s1;
			seq_rot_q <= {len_rot_s1, 16'h0000};
			seq_a_q <= len_a_s1;
			seq_len_q <= len_d_s1;
		end
	end

	// Corner angle and distance for the current count.
	logic [AW-1:0]        c_ang;
	logic signed [DW-1:0] c_dist;
	logic signed [DW-1:0] sx_dist;
	logic [AW-1:0]        c_turn;
	logic                 c_flip;
	logic [AW-1:0]        c_th;
	logic signed [DW+30:0] c_prod;

	assign sx_dist = $signed(DW'({seq_sx_q, 8'h00}));

	always_comb begin
		unique case (seq_cnt_q)
			2'd0: begin
				c_ang = seq_rot_q + HALF_TURN + seq_a_q;
				c_dist = seq_len_q;
			end
			2'd1: begin
				c_ang = seq_rot_q + HALF_TURN - seq_a_q;
				c_dist = seq_len_q;
			end
			2'd2: begin
				c_ang = seq_bot_q ? (seq_rot_q - QUARTER_TURN) : (seq_rot_q - seq_a_q);
				c_dist = seq_bot_q ? sx_dist : seq_len_q;
			end
			default: begin
				c_ang = seq_bot_q ? (seq_rot_q + QUARTER_TURN) : (seq_rot_q + seq_a_q);
				c_dist = seq_bot_q ? sx_dist : seq_len_q;
			end
		endcase
	end

	// Fold the angle into the right half plane; the result is negated later.
	assign c_turn = c_ang + QUARTER_TURN;
	assign c_flip = c_turn[AW-1];
	assign c_th = {c_ang[AW-1] ^ c_flip, c_ang[AW-2:0]};
	assign c_prod = c_dist * INV_GAIN;

	// Rotation row, fed by the start vector register.
	rot_beat_t rchain [NS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rchain[0] <= '0;
		end else if (en_o) begin
			rchain[0].valid <= seq_valid_q;
			rchain[0].last <= (seq_cnt_q == 2'd3);
			rchain[0].corner <= seq_cnt_q;
			rchain[0].flip <= c_flip;
			rchain[0].x <= c_prod[30+RW-1:30];
			rchain[0].y <= '0;
			rchain[0].z <= $signed(c_th);
		end
	end

	generate
		for (gi = 0; gi < NS; gi++) begin : g_rot
			bqcg_rot_cell #(.STEP(gi)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (en_o),
				.d      (rchain[gi]),
				.q      (rchain[gi+1])
			);
		end
	endgenerate

	// Output register: undo the fold, round and saturate.
	rot_beat_t            rend;
	logic signed [RW:0]   fx;
	logic signed [RW:0]   fy;
	logic                 out_valid_q;
	logic                 out_last_q;
	logic [1:0]           out_corner_q;
	logic signed [17:0]   out_px_q;
	logic signed [17:0]   out_py_q;

	assign rend = rchain[NS];
	assign fx = rend.flip ? -(RW+1)'(rend.x) : (RW+1)'(rend.x);
	assign fy = rend.flip ? -(RW+1)'(rend.y) : (RW+1)'(rend.y);
	assign en_o = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_o) begin
			out_valid_q <= rend.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_o) begin
			out_last_q <= rend.last;
			out_corner_q <= rend.corner;
			out_px_q <= to_q4(fy);
			out_py_q <= to_q4(-fx);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast = out_last_q;
	assign m_tdata = {2'b00, out_py_q, out_px_q, out_corner_q};

	`BQCG_ASSERT_NOW(a_last_on_corner3, m_tvalid, m_tlast == (m_tdata[1:0] == 2'd3),
		"tlast does not match corner 3")
	`BQCG_ASSERT_NOW(a_cnt_needs_item, seq_cnt_q != 2'd0, seq_valid_q,
		"corner count running without a sprite")
	`BQCG_ASSERT_NEXT(a_seq_drains, seq_done && !len_valid_s1, !seq_valid_q,
		"sequencer kept a finished sprite")
	`BQCG_ASSERT_NEXT(a_out_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
		"stalled output beat changed")

endmodule
